// ===== src/bootloader_command_engine_assert.svh =====
// Assertion macros used by the checker file.
`ifndef BOOTLOADER_COMMAND_ENGINE_ASSERT_SVH
`define BOOTLOADER_COMMAND_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define BCE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bce check failed");

// Next-cycle implication, disabled while rst is high.
`define BCE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bce check failed");

`endif

// ===== src/bce_pkg.sv =====
`default_nettype none

package bce_pkg;

   // Field widths
   localparam int LenW   = 4;
   localparam int CmdW   = 8;
   localparam int WordW  = 32;
   localparam int SizeW  = 21;
   localparam int TickW  = 16;
   localparam int IdleW  = 17;
   localparam int ErrW   = 3;
   localparam int CsrAW  = 3;
   localparam int ReqDW  = 80;
   localparam int RspDW  = 80;

   localparam logic [IdleW-1:0] IdleMax  = 17'h1FFFF;
   localparam logic [WordW-1:0] RamLow   = 32'h2000_0000;
   localparam logic [WordW-1:0] RamHigh  = 32'h2002_0000;
   localparam logic [WordW-1:0] WordStep = 32'd4;
   localparam logic [LenW-1:0]  MinLen   = 4'd5;

   // Register reset values
   localparam logic [SizeW-1:0] RstMaxImage = 21'd376832;
   localparam logic [TickW-1:0] RstWait     = 16'd500;
   localparam logic [WordW-1:0] RstBase     = 32'd134234112;
   localparam logic [CmdW-1:0]  RstPing     = 8'd1;
   localparam logic [CmdW-1:0]  RstStart    = 8'd2;
   localparam logic [CmdW-1:0]  RstData     = 8'd3;
   localparam logic [CmdW-1:0]  RstCheck    = 8'd4;
   localparam logic [CmdW-1:0]  RstJump     = 8'd5;

   // Register indexes
   typedef enum logic [CsrAW-1:0] {
      CSR_MAX_IMAGE = 3'd0,
      CSR_WAIT      = 3'd1,
      CSR_BASE      = 3'd2,
      CSR_PING      = 3'd3,
      CSR_START     = 3'd4,
      CSR_DATA      = 3'd5,
      CSR_CHECK     = 3'd6,
      CSR_JUMP      = 3'd7
   } csr_idx_type;

   // Response error codes
   typedef enum logic [ErrW-1:0] {
      ERR_NONE    = 3'd0,
      ERR_NOSTART = 3'd1,
      ERR_SIZE    = 3'd2,
      ERR_ERASE   = 3'd3,
      ERR_WRITE   = 3'd4,
      ERR_CRC     = 3'd5,
      ERR_NOJUMP  = 3'd6
   } err_type;

   typedef struct packed {
      logic [SizeW-1:0] max_image_bytes;
      logic [TickW-1:0] wait_ticks;
      logic [WordW-1:0] image_base;
      logic [CmdW-1:0]  code_ping;
      logic [CmdW-1:0]  code_start;
      logic [CmdW-1:0]  code_data;
      logic [CmdW-1:0]  code_check;
      logic [CmdW-1:0]  code_jump;
   } cfg_type;

   typedef struct packed {
      logic             op;
      logic [LenW-1:0]  frame_len;
      logic [CmdW-1:0]  cmd_byte;
      logic [WordW-1:0] payload;
      logic [WordW-1:0] app_stack_word;
      logic             flash_ok;
   } item_type;

   typedef struct packed {
      logic             resp_valid;
      logic             resp_ack;
      err_type          err_code;
      logic             erase_req;
      logic             unlock_req;
      logic             lock_req;
      logic             write_req;
      logic [WordW-1:0] prog_addr;
      logic [WordW-1:0] write_data;
      logic             jump_req;
   } result_type;

   // Reflected CRC-32 nibble table (poly 0xEDB88320)
   function automatic logic [WordW-1:0] crc_nib(input logic [3:0] idx);
      logic [WordW-1:0] val;
      case (idx)
         4'h0:    val = 32'h00000000;
         4'h1:    val = 32'h1DB71064;
         4'h2:    val = 32'h3B6E20C8;
         4'h3:    val = 32'h26D930AC;
         4'h4:    val = 32'h76DC4190;
         4'h5:    val = 32'h6B6B51F4;
         4'h6:    val = 32'h4DB26158;
         4'h7:    val = 32'h5005713C;
         4'h8:    val = 32'hEDB88320;
         4'h9:    val = 32'hF00F9344;
         4'hA:    val = 32'hD6D6A3E8;
         4'hB:    val = 32'hCB61B38C;
         4'hC:    val = 32'h9B64C2B0;
         4'hD:    val = 32'h86D3D2D4;
         4'hE:    val = 32'hA00AE278;
         4'hF:    val = 32'hBDBDF21C;
         default: val = '0;
      endcase
      return val;
   endfunction

   // Fold one word, low nibble first, into the CRC (pre/post complement)
   function automatic logic [WordW-1:0] fold_word(input logic [WordW-1:0] crc,
                                                  input logic [WordW-1:0] word);
      logic [WordW-1:0] c;
      c = ~crc;
      for (int i = 0; i < WordW / 4; i++) begin
         c = (c >> 4) ^ crc_nib(c[3:0] ^ word[4*i +: 4]);
      end
      return ~c;
   endfunction

   function automatic logic stack_ok(input logic [WordW-1:0] sp);
      return (sp >= RamLow) && (sp <= RamHigh);
   endfunction

endpackage

`default_nettype wire

// ===== src/bce_csr.sv =====
`default_nettype none

module bce_csr
   import bce_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [CsrAW-1:0]   csr_addr,
   input  wire logic [WordW-1:0]   csr_wdata,
   output cfg_type                 cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_idx_type'(csr_addr))
            CSR_MAX_IMAGE: cfg_in.max_image_bytes = csr_wdata[SizeW-1:0];
            CSR_WAIT:      cfg_in.wait_ticks      = csr_wdata[TickW-1:0];
            CSR_BASE:      cfg_in.image_base      = csr_wdata;
            CSR_PING:      cfg_in.code_ping       = csr_wdata[CmdW-1:0];
            CSR_START:     cfg_in.code_start      = csr_wdata[CmdW-1:0];
            CSR_DATA:      cfg_in.code_data       = csr_wdata[CmdW-1:0];
            CSR_CHECK:     cfg_in.code_check      = csr_wdata[CmdW-1:0];
            CSR_JUMP:      cfg_in.code_jump       = csr_wdata[CmdW-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_image_bytes <= RstMaxImage;
         cfg_ff.wait_ticks      <= RstWait;
         cfg_ff.image_base      <= RstBase;
         cfg_ff.code_ping       <= RstPing;
         cfg_ff.code_start      <= RstStart;
         cfg_ff.code_data       <= RstData;
         cfg_ff.code_check      <= RstCheck;
         cfg_ff.code_jump       <= RstJump;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== src/bce_in_reg.sv =====
`default_nettype none

module bce_in_reg
   import bce_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   output logic           in_ready,
   input  item_type       in_item,
   input  wire logic      advance,
   output logic           stage_valid,
   output item_type       stage_item
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     load;

   // take a new word whenever the stage is empty or moving on
   assign in_ready = !valid_ff || advance;
   assign load     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= in_item;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_item  = item_ff;

endmodule

`default_nettype wire

// ===== src/bce_exec.sv =====
`default_nettype none

module bce_exec
   import bce_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  cfg_type        cfg,
   input  item_type       item,
   input  wire logic      advance,
   output result_type     result
);

   logic [WordW-1:0] addr_ff,   addr_in;
   logic [WordW-1:0] crc_ff,    crc_in;
   logic             active_ff, active_in;
   logic             open_ff,   open_in;
   logic [IdleW-1:0] idle_ff,   idle_in;

   logic [IdleW-1:0] idle_inc;
   logic             len_ok;
   logic             sp_ok;
   logic [WordW-1:0] crc_fold;
   result_type       res;

   assign idle_inc = (idle_ff < IdleMax) ? idle_ff + 1'b1 : idle_ff;
   assign len_ok   = item.frame_len >= MinLen;
   assign sp_ok    = stack_ok(item.app_stack_word);
   assign crc_fold = fold_word(crc_ff, item.payload);

   // command decode and next state
   always_comb begin
      res       = '0;
      addr_in   = addr_ff;
      crc_in    = crc_ff;
      active_in = active_ff;
      open_in   = open_ff;
      idle_in   = idle_ff;

      if (item.op) begin
         // tick: count, fire timeout only outside a download
         idle_in = idle_inc;
         if (!active_ff && (idle_inc > {1'b0, cfg.wait_ticks})) begin
            if (sp_ok) begin
               res.jump_req = 1'b1;
               if (open_ff) begin
                  res.lock_req = 1'b1;
                  open_in      = 1'b0;
               end
            end
            idle_in = '0;
         end
      end else if (item.cmd_byte == cfg.code_ping) begin
         res.resp_valid = 1'b1;
         res.resp_ack   = 1'b1;
      end else if (item.cmd_byte == cfg.code_start) begin
         res.resp_valid = 1'b1;
         if (!len_ok) begin
            res.err_code = ERR_NOSTART;
         end else if ((item.payload == '0) ||
                      (item.payload > {{(WordW-SizeW){1'b0}}, cfg.max_image_bytes})) begin
            res.err_code = ERR_SIZE;
         end else begin
            res.erase_req = 1'b1;
            if (!item.flash_ok) begin
               res.err_code = ERR_ERASE;
            end else begin
               res.unlock_req = 1'b1;
               res.resp_ack   = 1'b1;
               open_in        = 1'b1;
               addr_in        = cfg.image_base;
               crc_in         = '0;
               active_in      = 1'b1;
            end
         end
      end else if (item.cmd_byte == cfg.code_data) begin
         res.resp_valid = 1'b1;
         if (!active_ff) begin
            res.err_code = ERR_NOSTART;
         end else if (!len_ok) begin
            res.err_code = ERR_WRITE;
         end else begin
            res.write_req  = 1'b1;
            res.prog_addr  = addr_ff;
            res.write_data = item.payload;
            if (!item.flash_ok) begin
               res.err_code = ERR_WRITE;
            end else begin
               res.resp_ack = 1'b1;
               crc_in       = crc_fold;
               addr_in      = addr_ff + WordStep;
            end
         end
      end else if (item.cmd_byte == cfg.code_check) begin
         res.resp_valid = 1'b1;
         if (!active_ff) begin
            res.err_code = ERR_NOSTART;
         end else if (!len_ok || (crc_ff != item.payload)) begin
            res.err_code = ERR_CRC;
         end else begin
            res.resp_ack = 1'b1;
            res.lock_req = 1'b1;
            open_in      = 1'b0;
            active_in    = 1'b0;
         end
      end else if (item.cmd_byte == cfg.code_jump) begin
         res.resp_valid = 1'b1;
         if (!sp_ok) begin
            res.err_code = ERR_NOJUMP;
         end else begin
            res.resp_ack = 1'b1;
            res.jump_req = 1'b1;
            if (open_ff) begin
               res.lock_req = 1'b1;
               open_in      = 1'b0;
            end
         end
      end
   end

   // state commits when the word leaves the stage
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff   <= RstBase;
         crc_ff    <= '0;
         active_ff <= 1'b0;
         open_ff   <= 1'b0;
         idle_ff   <= '0;
      end else if (advance) begin
         addr_ff   <= addr_in;
         crc_ff    <= crc_in;
         active_ff <= active_in;
         open_ff   <= open_in;
         idle_ff   <= idle_in;
      end
   end

   assign result = res;

endmodule

`default_nettype wire

// ===== src/bce_out_reg.sv =====
`default_nettype none

module bce_out_reg
   import bce_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      stage_valid,
   input  result_type     result,
   output logic           advance,
   output logic           out_valid,
   input  wire logic      out_ready,
   output result_type     out_result
);

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   // stage moves on when the output register is free or draining
   assign advance = stage_valid && (!valid_ff || out_ready);

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

`default_nettype wire

// ===== src/bootloader_command_engine.sv =====
// Bootloader command engine.
// Input channel req_*: one word per received command frame or per 1 ms tick
// (req_tuser = 1 for a tick). Output channel rsp_*: exactly one word per input
// word, carrying the response frame fields and the flash/jump requests.
// Config port csr_*: register written on any clock edge with csr_we high;
// write only while the engine is idle.
// A word accepted into the input stage is decoded and CRC-folded in one pass,
// then registered in the output register that drives rsp_tvalid. Throughput:
// one word per cycle while rsp_tready is high. The limit is the single-pass
// decode with an 8-step nibble-table CRC fold between the two registers.
// Download state (address, CRC, flags, idle counter) commits when a word moves
// from the input stage into the output register.
// Reset (synchronous): both stages empty, registers at defaults, address at
// the default image base, CRC and idle count zero, no download, flash closed.
// Stall: while rsp_tready is low the output word holds, the input stage keeps
// one more word, and req_tready drops once both are full.
`default_nettype none

module bootloader_command_engine
   import bce_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // slave side
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   // [3:0] frame_len, [11:4] cmd_byte, [43:12] payload, [75:44] app_stack_word,
   // [76] flash_ok, [79:77] zero
   input  wire logic [ReqDW-1:0]   req_tdata,
   // [0] op
   input  wire logic               req_tuser,
   // master side
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   // [0] resp_valid, [1] resp_ack, [4:2] err_code, [5] erase_req, [6] unlock_req,
   // [7] lock_req, [8] write_req, [40:9] prog_addr, [72:41] write_data,
   // [73] jump_req, [79:74] zero
   output logic [RspDW-1:0]        rsp_tdata,
   // configuration
   input  wire logic               csr_we,
   input  wire logic [CsrAW-1:0]   csr_addr,
   input  wire logic [WordW-1:0]   csr_wdata
);

   cfg_type    cfg;
   item_type   req_item;
   item_type   stage_item;
   logic       stage_valid;
   logic       advance;
   result_type result;
   result_type out_result;

   // unpack input word
   assign req_item.op             = req_tuser;
   assign req_item.frame_len      = req_tdata[3:0];
   assign req_item.cmd_byte       = req_tdata[11:4];
   assign req_item.payload        = req_tdata[43:12];
   assign req_item.app_stack_word = req_tdata[75:44];
   assign req_item.flash_ok       = req_tdata[76];

   bce_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bce_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_item     (req_item),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage_item  (stage_item)
   );

   bce_exec u_exec (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .item    (stage_item),
      .advance (advance),
      .result  (result)
   );

   bce_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .result      (result),
      .advance     (advance),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_result  (out_result)
   );

   // pack output word
   assign rsp_tdata = {6'b0,
                       out_result.jump_req,
                       out_result.write_data,
                       out_result.prog_addr,
                       out_result.write_req,
                       out_result.lock_req,
                       out_result.unlock_req,
                       out_result.erase_req,
                       out_result.err_code,
                       out_result.resp_ack,
                       out_result.resp_valid};

endmodule

`default_nettype wire

// ===== src/bce_checker.sv =====
`default_nettype none

`include "bootloader_command_engine_assert.svh"

module bce_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [79:0] rsp_tdata
);

   // stalled output word holds
   `BCE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // no word left over after reset
   `BCE_ASSERT_NEXT(a_rst_empty, clock, 1'b0, reset, !rsp_tvalid)

   // ACK only on a sent response, and with no error code
   `BCE_ASSERT_NOW(a_ack_clean, clock, reset, rsp_tvalid && rsp_tdata[1], rsp_tdata[0] && (rsp_tdata[4:2] == 3'd0))

   // write address and data are zero without a write request
   `BCE_ASSERT_NOW(a_write_zero, clock, reset, rsp_tvalid && !rsp_tdata[8], (rsp_tdata[40:9] == 32'd0) && (rsp_tdata[72:41] == 32'd0))

   // no response frame: no ack, no error code
   `BCE_ASSERT_NOW(a_silent_zero, clock, reset, rsp_tvalid && !rsp_tdata[0], !rsp_tdata[1] && (rsp_tdata[4:2] == 3'd0))

endmodule

bind bootloader_command_engine bce_checker u_bce_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
module tb
   import bce_pkg::*;
;

   localparam logic [WordW-1:0] CrcPoly    = 32'hEDB8_8320;
   localparam logic [CmdW-1:0]  UnknownCmd = 8'hFF;
   localparam logic [LenW-1:0]  FullLen    = 4'd8;
   localparam logic [LenW-1:0]  ShortLen   = 4'd4;
   localparam int               DlTicks    = 40;
   localparam int               QuietLimit = 2000;
   localparam int               ShowMax    = 10;

   // Mirror of the engine: registers, download state and the responses still owed
   class boot_mirror;
      logic [SizeW-1:0] max_bytes;
      logic [TickW-1:0] wait_lim;
      logic [WordW-1:0] base;
      logic [CmdW-1:0]  c_ping, c_start, c_data, c_check, c_jump;
      logic [WordW-1:0] waddr;
      logic [WordW-1:0] crc;
      bit               dl_active;
      bit               flash_open;
      logic [IdleW-1:0] idle_cnt;
      result_type       rsp_due[$];
      int               faults;

      function new();
         max_bytes  = RstMaxImage;
         wait_lim   = RstWait;
         base       = RstBase;
         c_ping     = RstPing;
         c_start    = RstStart;
         c_data     = RstData;
         c_check    = RstCheck;
         c_jump     = RstJump;
         waddr      = RstBase;
         crc        = '0;
         dl_active  = 1'b0;
         flash_open = 1'b0;
         idle_cnt   = '0;
         faults     = 0;
      endfunction

      function void set_csr(csr_idx_type idx, logic [WordW-1:0] v);
         case (idx)
            CSR_MAX_IMAGE: max_bytes = v[SizeW-1:0];
            CSR_WAIT:      wait_lim  = v[TickW-1:0];
            CSR_BASE:      base      = v;
            CSR_PING:      c_ping    = v[CmdW-1:0];
            CSR_START:     c_start   = v[CmdW-1:0];
            CSR_DATA:      c_data    = v[CmdW-1:0];
            CSR_CHECK:     c_check   = v[CmdW-1:0];
            CSR_JUMP:      c_jump    = v[CmdW-1:0];
            default: ;
         endcase
      endfunction

      // Bitwise reflected CRC-32, one payload bit per step, low bit first
      function logic [WordW-1:0] crc_fold(logic [WordW-1:0] c0, logic [WordW-1:0] w);
         logic [WordW-1:0] c;
         c = ~c0;
         for (int i = 0; i < WordW; i++) begin
            c = (c >> 1) ^ ((c[0] ^ w[i]) ? CrcPoly : '0);
         end
         return ~c;
      endfunction

      function bit in_ram(logic [WordW-1:0] sp);
         return (sp >= RamLow) && (sp <= RamHigh);
      endfunction

      function void reply(inout result_type r, input bit ack, input err_type e);
         r.resp_valid = 1'b1;
         r.resp_ack   = ack;
         r.err_code   = ack ? ERR_NONE : e;
      endfunction

      // Work out the response to one accepted word and advance the state
      function void take_word(item_type w);
         result_type r;
         r = '0;
         if (w.op) begin
            if (idle_cnt < IdleMax) idle_cnt = idle_cnt + 1'b1;
            if (!dl_active && idle_cnt > wait_lim) begin
               if (in_ram(w.app_stack_word)) begin
                  r.jump_req = 1'b1;
                  if (flash_open) begin
                     r.lock_req = 1'b1;
                     flash_open = 1'b0;
                  end
               end
               idle_cnt = '0;
            end
         end else if (w.cmd_byte == c_ping) begin
            reply(r, 1'b1, ERR_NONE);
         end else if (w.cmd_byte == c_start) begin
            if (w.frame_len < MinLen) begin
               reply(r, 1'b0, ERR_NOSTART);
            end else if (w.payload == '0 || w.payload > max_bytes) begin
               reply(r, 1'b0, ERR_SIZE);
            end else begin
               r.erase_req = 1'b1;
               if (!w.flash_ok) begin
                  reply(r, 1'b0, ERR_ERASE);
               end else begin
                  r.unlock_req = 1'b1;
                  flash_open   = 1'b1;
                  waddr        = base;
                  crc          = '0;
                  dl_active    = 1'b1;
                  reply(r, 1'b1, ERR_NONE);
               end
            end
         end else if (w.cmd_byte == c_data) begin
            if (!dl_active) begin
               reply(r, 1'b0, ERR_NOSTART);
            end else if (w.frame_len < MinLen) begin
               reply(r, 1'b0, ERR_WRITE);
            end else begin
               // write goes out before the flash status is known
               r.write_req  = 1'b1;
               r.prog_addr  = waddr;
               r.write_data = w.payload;
               if (!w.flash_ok) begin
                  reply(r, 1'b0, ERR_WRITE);
               end else begin
                  crc   = crc_fold(crc, w.payload);
                  waddr = waddr + WordStep;
                  reply(r, 1'b1, ERR_NONE);
               end
            end
         end else if (w.cmd_byte == c_check) begin
            if (!dl_active) begin
               reply(r, 1'b0, ERR_NOSTART);
            end else if (w.frame_len < MinLen || crc != w.payload) begin
               reply(r, 1'b0, ERR_CRC);
            end else begin
               r.lock_req = 1'b1;
               flash_open = 1'b0;
               dl_active  = 1'b0;
               reply(r, 1'b1, ERR_NONE);
            end
         end else if (w.cmd_byte == c_jump) begin
            if (!in_ram(w.app_stack_word)) begin
               reply(r, 1'b0, ERR_NOJUMP);
            end else begin
               reply(r, 1'b1, ERR_NONE);
               r.jump_req = 1'b1;
               if (flash_open) begin
                  r.lock_req = 1'b1;
                  flash_open = 1'b0;
               end
            end
         end
         rsp_due.push_back(r);
      endfunction

      function string show(result_type r);
         return $sformatf({"valid=%0b ack=%0b err=%0d erase=%0b unlock=%0b lock=%0b",
                           " write=%0b addr=%h data=%h jump=%0b"},
                          r.resp_valid, r.resp_ack, r.err_code, r.erase_req, r.unlock_req,
                          r.lock_req, r.write_req, r.prog_addr, r.write_data, r.jump_req);
      endfunction

      // Compare one response word against the oldest owed response
      function void check_rsp(logic [RspDW-1:0] d);
         result_type g;
         result_type e;
         string      bad;
         g.resp_valid = d[0];
         g.resp_ack   = d[1];
         g.err_code   = err_type'(d[4:2]);
         g.erase_req  = d[5];
         g.unlock_req = d[6];
         g.lock_req   = d[7];
         g.write_req  = d[8];
         g.prog_addr  = d[40:9];
         g.write_data = d[72:41];
         g.jump_req   = d[73];
         if (rsp_due.size() == 0) begin
            faults++;
            if (faults <= ShowMax) $display("rsp word with nothing owed: %s", show(g));
            return;
         end
         e = rsp_due.pop_front();
         bad = "";
         if (g.resp_valid !== e.resp_valid) bad = {bad, " resp_valid"};
         if (g.resp_ack   !== e.resp_ack)   bad = {bad, " resp_ack"};
         if (g.err_code   !== e.err_code)   bad = {bad, " err_code"};
         if (g.erase_req  !== e.erase_req)  bad = {bad, " erase_req"};
         if (g.unlock_req !== e.unlock_req) bad = {bad, " unlock_req"};
         if (g.lock_req   !== e.lock_req)   bad = {bad, " lock_req"};
         if (g.write_req  !== e.write_req)  bad = {bad, " write_req"};
         if (g.prog_addr  !== e.prog_addr)  bad = {bad, " prog_addr"};
         if (g.write_data !== e.write_data) bad = {bad, " write_data"};
         if (g.jump_req   !== e.jump_req)   bad = {bad, " jump_req"};
         if (bad != "") begin
            faults++;
            if (faults <= ShowMax) begin
               $display("rsp word differs in%s", bad);
               $display("  expected %s", show(e));
               $display("  actual   %s", show(g));
            end
         end
      endfunction
   endclass

   logic               clock;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [ReqDW-1:0]   req_tdata  = '0;
   logic               req_tuser  = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RspDW-1:0]   rsp_tdata;
   logic               csr_we     = 1'b0;
   logic [CsrAW-1:0]   csr_addr   = '0;
   logic [WordW-1:0]   csr_wdata  = '0;

   boot_mirror mirror;
   int  words_sent   = 0;
   int  burst_left   = 0;
   int  quiet_cycles = 0;
   int  rx_tick      = 0;
   int  rx_mode      = 0;
   bit  steady       = 1'b0;
   bit  rx_open      = 1'b0;

   bootloader_command_engine u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver stall pattern: switches at random between four styles
   always @(posedge clock) begin
      rx_tick++;
      if (rx_tick % 97 == 0) rx_mode = $urandom_range(0, 3);
      if (rx_open) begin
         rsp_tready <= 1'b1;
      end else begin
         case (rx_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= ($urandom_range(0, 3) != 0);
            2:       rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= ((rx_tick % 9) < 4);
         endcase
      end
   end

   // Response check and progress tracking
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) mirror.check_rsp(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
   end

   // Watchdog: nothing moved for too long
   initial begin
      while (quiet_cycles < QuietLimit) @(posedge clock);
      $display("bootloader_command_engine: mismatch");
      $finish;
   end

   function automatic item_type mk(logic op, logic [LenW-1:0] len, logic [CmdW-1:0] cmd,
                                   logic [WordW-1:0] pay, logic [WordW-1:0] sp, logic ok);
      item_type w;
      w.op             = op;
      w.frame_len      = len;
      w.cmd_byte       = cmd;
      w.payload        = pay;
      w.app_stack_word = sp;
      w.flash_ok       = ok;
      return w;
   endfunction

   function automatic logic [WordW-1:0] rand_word();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return 32'd1 << $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [WordW-1:0] rand_sp();
      case ($urandom_range(0, 7))
         0:       return RamLow - 1;
         1:       return RamLow;
         2:       return RamHigh;
         3:       return RamHigh + 1;
         4, 5:    return RamLow + $urandom_range(0, 32'h2_0000);
         6:       return $urandom;
         default: return rand_word();
      endcase
   endfunction

   function automatic logic [LenW-1:0] good_len();
      return ($urandom_range(0, 3) == 0) ? LenW'($urandom_range(5, 15)) : FullLen;
   endfunction

   function automatic logic [LenW-1:0] short_len();
      return LenW'($urandom_range(0, 4));
   endfunction

   function automatic logic [WordW-1:0] start_size();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 32'(mirror.max_bytes) + 1;
         2:       return $urandom;
         3:       return 32'(mirror.max_bytes);
         4:       return 32'd1;
         default: return $urandom_range(1, 32'(mirror.max_bytes));
      endcase
   endfunction

   function automatic logic [CmdW-1:0] pick_code();
      case ($urandom_range(0, 5))
         0:       return mirror.c_ping;
         1:       return mirror.c_start;
         2:       return mirror.c_data;
         3:       return mirror.c_check;
         4:       return mirror.c_jump;
         default: return CmdW'($urandom_range(0, 255));
      endcase
   endfunction

   // Present one word, wait for it to be taken, then maybe pause between bursts
   task automatic send_word(item_type w);
      req_tdata  <= {3'b000, w.flash_ok, w.app_stack_word, w.payload, w.cmd_byte,
                     w.frame_len};
      req_tuser  <= w.op;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      mirror.take_word(w);
      words_sent++;
      if (!steady) begin
         if (burst_left == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 6);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic send_frame(logic [CmdW-1:0] cmd, logic [LenW-1:0] len,
                             logic [WordW-1:0] pay, logic [WordW-1:0] sp, logic ok);
      send_word(mk(1'b0, len, cmd, pay, sp, ok));
   endtask

   task automatic send_tick(logic [WordW-1:0] sp);
      send_word(mk(1'b1, LenW'($urandom_range(0, 15)), CmdW'($urandom_range(0, 255)),
                   $urandom, sp, 1'($urandom_range(0, 1))));
   endtask

   // Stop sending and let every owed response drain
   task automatic settle();
      req_tvalid <= 1'b0;
      while (mirror.rsp_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(csr_idx_type idx, logic [WordW-1:0] v);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= v;
      @(posedge clock);
      mirror.set_csr(idx, v);
   endtask

   task automatic write_all(logic [WordW-1:0] max_b, logic [WordW-1:0] wait_t,
                            logic [WordW-1:0] img, logic [CmdW-1:0] p, logic [CmdW-1:0] s,
                            logic [CmdW-1:0] d, logic [CmdW-1:0] c, logic [CmdW-1:0] j);
      settle();
      write_csr(CSR_MAX_IMAGE, max_b);
      write_csr(CSR_WAIT, wait_t);
      write_csr(CSR_BASE, img);
      write_csr(CSR_PING, 32'(p));
      write_csr(CSR_START, 32'(s));
      write_csr(CSR_DATA, 32'(d));
      write_csr(CSR_CHECK, 32'(c));
      write_csr(CSR_JUMP, 32'(j));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // START, a run of DATA words with stray ticks, then CHECK and maybe JUMP
   task automatic download();
      int n;
      n = $urandom_range(1, 10);
      send_frame(mirror.c_start, good_len(), start_size(), rand_sp(),
                 $urandom_range(0, 9) != 0);
      repeat (n) begin
         if ($urandom_range(0, 5) == 0) send_tick(rand_sp());
         send_frame(mirror.c_data, ($urandom_range(0, 9) == 0) ? short_len() : good_len(),
                    rand_word(), rand_sp(), $urandom_range(0, 9) != 0);
      end
      send_frame(mirror.c_check, ($urandom_range(0, 19) == 0) ? short_len() : good_len(),
                 ($urandom_range(0, 7) == 0) ? rand_word() : mirror.crc, rand_sp(),
                 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) == 0)
         send_frame(mirror.c_jump, good_len(), rand_word(), rand_sp(),
                    1'($urandom_range(0, 1)));
   endtask

   task automatic idle_ticks();
      int span;
      span = (mirror.wait_lim < 40) ? int'(mirror.wait_lim) + 3 : 40;
      repeat ($urandom_range(1, span)) send_tick(rand_sp());
   endtask

   task automatic noise();
      send_word(mk($urandom_range(0, 3) == 0, LenW'($urandom_range(0, 15)), pick_code(),
                   rand_word(), rand_sp(), 1'($urandom_range(0, 1))));
   endtask

   task automatic random_phase(int count);
      int stop_at;
      int k;
      stop_at = words_sent + count;
      while (words_sent < stop_at) begin
         k = $urandom_range(0, 99);
         if (k < 55) begin
            download();
         end else if (k < 67) begin
            idle_ticks();
         end else if (k < 77) begin
            send_frame(($urandom_range(0, 1) != 0) ? mirror.c_ping : mirror.c_jump,
                       LenW'($urandom_range(0, 15)), rand_word(), rand_sp(),
                       1'($urandom_range(0, 1)));
         end else begin
            repeat ($urandom_range(1, 4)) noise();
         end
      end
   endtask

   initial begin
      mirror = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values: every command and each error path
      send_frame(mirror.c_ping, FullLen, '0, RamLow, 1'b1);
      send_frame(mirror.c_data, FullLen, 32'hA5A5_A5A5, RamLow, 1'b1);
      send_frame(mirror.c_check, FullLen, '0, RamLow, 1'b1);
      send_frame(mirror.c_start, ShortLen, 32'd100, RamLow, 1'b1);
      send_frame(mirror.c_start, FullLen, '0, RamLow, 1'b1);
      send_frame(mirror.c_start, FullLen, 32'(mirror.max_bytes) + 1, RamLow, 1'b1);
      send_frame(mirror.c_start, FullLen, 32'(mirror.max_bytes), RamLow, 1'b0);
      send_frame(mirror.c_start, MinLen, 32'(mirror.max_bytes), RamLow, 1'b1);
      send_frame(mirror.c_data, ShortLen, 32'h1111_1111, RamLow, 1'b1);
      send_frame(mirror.c_data, FullLen, 32'hDEAD_BEEF, RamLow, 1'b0);
      send_frame(mirror.c_data, 4'hF, '1, RamLow, 1'b1);
      send_frame(mirror.c_data, FullLen, '0, RamLow, 1'b1);
      send_frame(mirror.c_check, ShortLen, mirror.crc, RamLow, 1'b1);
      send_frame(mirror.c_check, FullLen, ~mirror.crc, RamLow, 1'b1);
      send_tick(RamLow);
      // START during a download restarts it
      send_frame(mirror.c_start, FullLen, 32'd1, RamLow, 1'b1);
      send_frame(mirror.c_data, FullLen, 32'h1234_5678, RamLow, 1'b1);
      // JUMP with the flash open locks it but keeps the download
      send_frame(mirror.c_jump, FullLen, '0, RamHigh, 1'b1);
      send_frame(mirror.c_check, FullLen, mirror.crc, RamLow, 1'b1);
      send_frame(mirror.c_jump, FullLen, '0, RamLow - 1, 1'b1);
      send_frame(mirror.c_jump, FullLen, '0, RamHigh + 1, 1'b1);
      send_frame(mirror.c_jump, FullLen, '0, RamLow, 1'b0);
      send_frame(UnknownCmd, FullLen, $urandom, $urandom, 1'b1);
      send_frame(UnknownCmd, 4'h0, '0, '0, 1'b0);
      send_tick(RamHigh);

      // Smallest size and wait, image base close to the top so the address wraps
      write_all(32'd1, 32'd0, 32'hFFFF_FFF8, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01);
      send_tick(RamLow);
      send_tick('0);
      send_frame(mirror.c_start, FullLen, 32'd2, RamLow, 1'b1);
      send_frame(mirror.c_start, FullLen, 32'd1, RamLow, 1'b1);
      repeat (3) send_frame(mirror.c_data, FullLen, $urandom, RamLow, 1'b1);
      send_tick(RamLow);
      send_frame(mirror.c_check, MinLen, mirror.crc, RamLow, 1'b1);
      send_tick(RamLow);
      random_phase(200);

      // Size limit 1048576 and largest wait; back-to-back ticks counted during a download
      write_all(32'd1048576, 32'd65535, '0, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01);
      steady  = 1'b1;
      rx_open = 1'b1;
      send_frame(mirror.c_start, FullLen, 32'd4, RamLow, 1'b1);
      repeat (DlTicks) send_tick(RamLow + 32'h100);
      send_frame(mirror.c_check, FullLen, mirror.crc, RamLow, 1'b1);
      send_tick(RamHigh);
      steady  = 1'b0;
      rx_open = 1'b0;

      // Shared codes: first match in command order wins
      write_all(32'd1048576, 32'd65535, '0, 8'h09, 8'h09, 8'h10, 8'h10, 8'h11);
      random_phase(150);

      // Random register values with short waits
      write_all($urandom_range(1, 1048576), $urandom_range(1, 30), $urandom,
                CmdW'($urandom_range(0, 255)), CmdW'($urandom_range(0, 255)),
                CmdW'($urandom_range(0, 255)), CmdW'($urandom_range(0, 255)),
                CmdW'($urandom_range(0, 255)));
      random_phase(250);

      // Back to the default codes with a short wait
      write_all(32'(RstMaxImage), 32'd2, RstBase, RstPing, RstStart, RstData, RstCheck,
                RstJump);
      random_phase(200);

      settle();
      repeat (8) @(posedge clock);
      mirror.faults += mirror.rsp_due.size();
      if (mirror.faults == 0) begin
         $display("bootloader_command_engine: match");
      end else begin
         $display("bootloader_command_engine: mismatch");
      end
      $finish;
   end

endmodule

// ===== bootloader_command_engine.f =====
+incdir+src
src/bce_pkg.sv
src/bce_csr.sv
src/bce_in_reg.sv
src/bce_exec.sv
src/bce_out_reg.sv
src/bootloader_command_engine.sv
src/bce_checker.sv
tb/tb.sv
